// ===== hdl/hcnt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcnt_pkg
// Shared types, command codes and helper functions for the hexamer counter.
// ----------------------------------------------------------------------------
package hcnt_pkg;

  localparam int CODE_W     = 12;
  localparam int HIST_DEPTH = 4096;
  localparam int RUN_W      = 3;
  localparam int OUT_W      = 32;

  localparam logic [RUN_W-1:0] HEX_LEN = 3'd6;

  localparam logic [1:0] CMD_BASE  = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [7:0] CHAR_A_UC = 8'h41;
  localparam logic [7:0] CHAR_C_UC = 8'h43;
  localparam logic [7:0] CHAR_G_UC = 8'h47;
  localparam logic [7:0] CHAR_T_UC = 8'h54;
  localparam logic [7:0] CHAR_A_LC = 8'h61;
  localparam logic [7:0] CHAR_C_LC = 8'h63;
  localparam logic [7:0] CHAR_G_LC = 8'h67;
  localparam logic [7:0] CHAR_T_LC = 8'h74;

  typedef struct packed {
    logic [1:0]        command;
    logic [7:0]        base_char;
    logic [CODE_W-1:0] query_code;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0]  hexamer_count;
    logic [OUT_W-1:0]  revcomp_count;
    logic [CODE_W-1:0] revcomp_code;
    logic [OUT_W-1:0]  total_hexamers;
    logic [OUT_W-1:0]  genes_seen;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic write_back;
    logic read_rc;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic hit;
    logic is_query;
  } dp_sts_t;

  // bit 2 marks a valid base
  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] r;
    unique case (ch)
      CHAR_A_UC, CHAR_A_LC: r = 3'b100;
      CHAR_C_UC, CHAR_C_LC: r = 3'b101;
      CHAR_G_UC, CHAR_G_LC: r = 3'b110;
      CHAR_T_UC, CHAR_T_LC: r = 3'b111;
      default:              r = 3'b000;
    endcase
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] revcomp(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] r;
    for (int i = 0; i < CODE_W / 2; i++) begin
      r[CODE_W-1-2*i -: 2] = ~code[2*i +: 2];
    end
    return r;
  endfunction

endpackage

// ===== hdl/hcnt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcnt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hcnt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/hcnt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcnt_ctrl
// Controller: clearing sweep, read-modify-write and two-read query sequencing.
// ----------------------------------------------------------------------------
module hcnt_ctrl
  import hcnt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_Q1    = 3'd3;
  localparam logic [2:0] S_Q2    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_ready && in_valid;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.accept     = accept;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          priority if (sts.is_query) begin
            state_nxt = S_Q1;
          end else if (sts.hit) begin
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        cmd.write_back = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_Q1: begin
        cmd.read_rc = 1'b1;
        state_nxt   = S_Q2;
      end
      S_Q2: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/hcnt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcnt_dp
// Datapath: hexamer window, run and gene counters, totals, histogram access
// and the result register.
// ----------------------------------------------------------------------------
module hcnt_dp
  import hcnt_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_cmd_t              cmd,
  output dp_sts_t                sts,
  input  in_item_t               in_data,
  output logic                   ram_we,
  output logic [CODE_W-1:0]      ram_waddr,
  output logic [COUNT_WIDTH-1:0] ram_wdata,
  output logic                   ram_re,
  output logic [CODE_W-1:0]      ram_raddr,
  input  logic [COUNT_WIDTH-1:0] ram_rdata,
  output out_item_t              out_data
);

  logic [CODE_W-1:0]      window_r, window_nxt;
  logic [RUN_W-1:0]       run_r, run_nxt;
  logic [RUN_W-1:0]       glen_r, glen_nxt;
  logic [COUNT_WIDTH-1:0] hex_total_r, hex_total_nxt;
  logic [COUNT_WIDTH-1:0] gene_total_r, gene_total_nxt;
  logic [CODE_W-1:0]      clr_addr_r;
  logic [CODE_W-1:0]      addr_r;
  logic [COUNT_WIDTH-1:0] hexcnt_r;
  out_item_t              out_r;

  logic [2:0]             bcode;
  logic [RUN_W-1:0]       run_inc;
  logic [CODE_W-1:0]      shifted;
  logic                   is_base;
  logic                   is_end;
  logic                   hit;

  logic [COUNT_WIDTH+OUT_W-1:0] ext_hex, ext_rc, ext_tot, ext_gene;

  assign bcode   = base_code(in_data.base_char);
  assign is_base = (in_data.command == CMD_BASE);
  assign is_end  = (in_data.command == CMD_END);
  assign run_inc = (run_r < HEX_LEN) ? run_r + 1'b1 : run_r;
  assign shifted = {window_r[CODE_W-3:0], bcode[1:0]};
  assign hit     = is_base && bcode[2] && (run_inc == HEX_LEN);

  assign sts.hit        = hit;
  assign sts.is_query   = (in_data.command == CMD_QUERY);
  assign sts.clear_done = (clr_addr_r == {CODE_W{1'b1}});

  always_comb begin
    window_nxt     = window_r;
    run_nxt        = run_r;
    glen_nxt       = glen_r;
    hex_total_nxt  = hex_total_r;
    gene_total_nxt = gene_total_r;
    if (cmd.accept && is_base) begin
      glen_nxt = (glen_r < HEX_LEN) ? glen_r + 1'b1 : glen_r;
      if (bcode[2]) begin
        window_nxt = shifted;
        run_nxt    = run_inc;
        if (hit) begin
          hex_total_nxt = (&hex_total_r) ? hex_total_r : hex_total_r + 1'b1;
        end
      end else begin
        window_nxt = '0;
        run_nxt    = '0;
      end
    end else if (cmd.accept && is_end) begin
      if (glen_r >= HEX_LEN) begin
        gene_total_nxt = (&gene_total_r) ? gene_total_r : gene_total_r + 1'b1;
      end
      window_nxt = '0;
      run_nxt    = '0;
      glen_nxt   = '0;
    end
  end

  // histogram port control
  assign ram_re    = (cmd.accept && (hit || sts.is_query)) || cmd.read_rc;
  assign ram_raddr = cmd.accept ? (sts.is_query ? in_data.query_code : shifted) : addr_r;
  assign ram_we    = cmd.clear || cmd.write_back;
  assign ram_waddr = cmd.clear ? clr_addr_r : addr_r;
  assign ram_wdata = cmd.clear ? '0 : ((&ram_rdata) ? ram_rdata : ram_rdata + 1'b1);

  assign ext_hex  = {{OUT_W{1'b0}}, hexcnt_r};
  assign ext_rc   = {{OUT_W{1'b0}}, ram_rdata};
  assign ext_tot  = {{OUT_W{1'b0}}, hex_total_r};
  assign ext_gene = {{OUT_W{1'b0}}, gene_total_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      run_r        <= '0;
      glen_r       <= '0;
      hex_total_r  <= '0;
      gene_total_r <= '0;
      clr_addr_r   <= '0;
    end else begin
      window_r     <= window_nxt;
      run_r        <= run_nxt;
      glen_r       <= glen_nxt;
      hex_total_r  <= hex_total_nxt;
      gene_total_r <= gene_total_nxt;
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= sts.is_query ? revcomp(in_data.query_code) : shifted;
    end
    if (cmd.read_rc) begin
      hexcnt_r <= ram_rdata;
    end
    if (cmd.out_load) begin
      out_r.hexamer_count  <= ext_hex[OUT_W-1:0];
      out_r.revcomp_count  <= ext_rc[OUT_W-1:0];
      out_r.revcomp_code   <= addr_r;
      out_r.total_hexamers <= ext_tot[OUT_W-1:0];
      out_r.genes_seen     <= ext_gene[OUT_W-1:0];
    end
  end

  assign out_data = out_r;

endmodule

// ===== hdl/hexamer_count_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexamer_count_histogram
// Counts hexamers of DNA sequence characters into a 4096-entry histogram and
// answers count queries for a code and its reverse complement.
//
//   channel   ports                         direction
//   input     in_valid  in_ready  in_data   in
//   result    out_valid out_ready out_data  out
//
// after reset a clearing pass writes zero to all 4096 histogram entries,
// one per cycle, during which in_ready is low
// a character that completes a hexamer reads its entry when accepted and
// writes it back in S_UPD; other characters, gene ends and unused commands
// are taken in S_IDLE alone; a query makes two reads on the single histogram
// read port and stalls in S_Q2 only while the result register is held by
// out_ready low; other items still flow past a waiting result
// ----------------------------------------------------------------------------
module hexamer_count_histogram
  import hcnt_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t              cmd;
  dp_sts_t                sts;
  logic                   ram_we;
  logic [CODE_W-1:0]      ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [CODE_W-1:0]      ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  hcnt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hcnt_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_data  (out_data)
  );

  hcnt_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== hdl/hcnt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcnt_checker
// Port-level checks for the hexamer counter, bound to the top level.
// ----------------------------------------------------------------------------
module hcnt_checker
  import hcnt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // reset starts the clearing pass with nothing pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("busy or result pending after reset");

  // an accepted query holds off further input while its reads run
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_QUERY |=> !in_ready)
    else $error("input taken during query reads");

  // a result is only produced from a busy query sequence
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without query sequence");

  // a waiting transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

endmodule

bind hexamer_count_histogram hcnt_checker u_hcnt_checker (.*);
